// File: sv/ttp_pkg.sv
// ttp_pkg: types, character codes and constant tables for the time text parser
// no dependencies; used by time_text_parser

package ttp_pkg;

   // parser phase
   typedef enum logic [3:0] {
      PH_SIGN  = 4'd0,
      PH_SIGN2 = 4'd1,
      PH_HOUR  = 4'd2,
      PH_MIN   = 4'd3,
      PH_SEC   = 4'd4,
      PH_FRAC  = 4'd5,
      PH_MER_A = 4'd6,
      PH_MER_P = 4'd7,
      PH_DONE  = 4'd8,
      PH_TRAIL = 4'd9
   } phase_type;

   typedef enum logic [1:0] {
      MER_NONE = 2'd0,
      MER_AM   = 2'd1,
      MER_PM   = 2'd2
   } meridian_type;

   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_FIVE  = 8'h35;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UC_A  = 8'h41;
   localparam logic [7:0] CH_LC_A  = 8'h61;
   localparam logic [7:0] CH_UC_P  = 8'h50;
   localparam logic [7:0] CH_LC_P  = 8'h70;
   localparam logic [7:0] CH_UC_M  = 8'h4D;
   localparam logic [7:0] CH_LC_M  = 8'h6D;

   localparam logic [34:0] FIELD_MAX       = 35'h07FFFFFFF;
   localparam logic [62:0] TOTAL_MAX       = '1;
   localparam logic [29:0] NS_PER_SEC      = 30'd1000000000;
   localparam logic [21:0] HOUR_LIMIT_INIT = 22'd2562047;
   localparam logic [21:0] MERIDIAN_HOURS  = 22'd12;
   localparam logic [3:0]  SCALE_DIGITS    = 4'd9;

   // register addresses (word index)
   localparam logic CSR_HOUR_LIMIT = 1'b0;

   typedef struct packed {
      logic [7:0] char_code;
      logic       is_last;
   } req_data_type;

   typedef struct packed {
      logic               ok;
      logic signed [63:0] nanoseconds;
      logic               trailing_ignored;
   } rsp_data_type;

   typedef struct packed {
      phase_type    phase;
      logic         negative;
      logic [30:0]  hour_field;
      logic [30:0]  minute_field;
      logic [30:0]  second_field;
      logic [29:0]  fraction_field;
      logic [3:0]   fraction_digits;
      logic [3:0]   field_seen;
      meridian_type meridian;
      logic         failed;
   } parse_state_type;

   localparam parse_state_type PARSE_CLEAR = '{
      phase: PH_SIGN, negative: 1'b0, hour_field: '0, minute_field: '0,
      second_field: '0, fraction_field: '0, fraction_digits: '0,
      field_seen: '0, meridian: MER_NONE, failed: 1'b0};

   // finish pipeline stages
   typedef struct packed {
      logic        bad;
      logic        hour_mode;
      logic [31:0] minutes;
      logic [30:0] seconds;
      logic [29:0] fraction;
      logic        negative;
      logic        trailing;
   } stage2_type;

   typedef struct packed {
      logic        bad;
      logic [37:0] whole;
      logic [29:0] fraction;
      logic        negative;
      logic        trailing;
   } stage3_type;

   typedef struct packed {
      logic        bad;
      logic [61:0] prod_lo;
      logic [35:0] prod_hi;
      logic [29:0] fraction;
      logic        negative;
      logic        trailing;
   } stage4_type;

   typedef struct packed {
      logic        good;
      logic [62:0] magnitude;
      logic        negative;
      logic        trailing;
   } stage5_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_sign(input logic [7:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS);
   endfunction

   // f * 10 + d, wide enough to see an overflow past 31 bits
   function automatic logic [34:0] times_ten_plus(input logic [30:0] f, input logic [3:0] d);
      return {1'b0, f, 3'b000} + {3'b000, f, 1'b0} + {31'd0, d};
   endfunction

   function automatic phase_type after_time(input logic [7:0] c);
      phase_type p;
      if (c == CH_UC_A || c == CH_LC_A) p = PH_MER_A;
      else if (c == CH_UC_P || c == CH_LC_P) p = PH_MER_P;
      else p = PH_TRAIL;
      return p;
   endfunction

   function automatic logic [29:0] pow10(input logic [3:0] idx);
      logic [29:0] v;
      case (idx)
         4'd0: v = 30'd1;
         4'd1: v = 30'd10;
         4'd2: v = 30'd100;
         4'd3: v = 30'd1000;
         4'd4: v = 30'd10000;
         4'd5: v = 30'd100000;
         4'd6: v = 30'd1000000;
         4'd7: v = 30'd10000000;
         4'd8: v = 30'd100000000;
         4'd9: v = 30'd1000000000;
         default: v = 30'd1;
      endcase
      return v;
   endfunction

endpackage

// File: sv/time_text_parser.sv
// time_text_parser: byte-wise parser for [+|-]H:MM[:SS[.frac]] [AM|PM] and M:SS.frac text
// depends on ttp_pkg for payload structs, phase codes and constant tables
//
// Usage
//   req channel: one text byte per transaction (char_code, is_last). A byte is
//   taken in every cycle that the finish pipeline can move, so text streams at
//   one byte per clock.
//   rsp channel: one transaction per string, issued for the byte marked last:
//   ok, signed nanosecond count and a flag for ignored trailing bytes.
//   Pipeline: after the last byte is accepted the result passes the snapshot
//   register, four finish stages (checks, scale to seconds, split 38 x 30 bit
//   multiply by 1e9, range check), then the output register.
//   Throughput: one byte per cycle, one result per cycle when strings are one
//   byte long, while rsp_ready does not stall the pipeline.
//   Stall: while rsp_ready is low the pipeline closes its bubbles; req_ready drops
//   only once the snapshot, every finish stage and the output register hold results.
//   Reset: parser state clears to "sign expected", all pipeline stages empty, hour_limit
//   returns to 2562047. Configuration: APB register hour_limit at byte address 0,
//   to be written by the user only while idle; the block does not enforce this.

module time_text_parser #(
   parameter int FRACTION_DIGITS = 9
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  ttp_pkg::req_data_type req_data,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ttp_pkg::rsp_data_type rsp_data,

   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [2:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam logic [3:0] FRAC_KEEP = 4'(FRACTION_DIGITS);

   logic [21:0]               hour_limit_ff;
   ttp_pkg::parse_state_type  parse_ff, parse_in, parse_next;
   ttp_pkg::parse_state_type  s1_ff;
   ttp_pkg::stage2_type       s2_ff, s2_in;
   ttp_pkg::stage3_type       s3_ff, s3_in;
   ttp_pkg::stage4_type       s4_ff, s4_in;
   ttp_pkg::stage5_type       s5_ff, s5_in;
   ttp_pkg::rsp_data_type     rsp_data_ff, rsp_data_in;
   logic [5:0]                pipe_valid_ff, pipe_valid_in;
   logic [5:0]                stage_load;
   logic                      req_accept;
   logic                      csr_write;

   // ---------------- configuration ----------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr[2] == ttp_pkg::CSR_HOUR_LIMIT);
   assign prdata    = (paddr[2] == ttp_pkg::CSR_HOUR_LIMIT) ? {10'd0, hour_limit_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         hour_limit_ff <= ttp_pkg::HOUR_LIMIT_INIT;
      end else if (csr_write) begin
         hour_limit_ff <= pwdata[21:0];
      end
   end

   // ---------------- pipeline flow ----------------
   // a stage can take new data when it is empty or its content moves on
   always_comb begin
      stage_load[5] = !pipe_valid_ff[5] || rsp_ready;
      for (int i = 4; i >= 0; i--) begin
         stage_load[i] = !pipe_valid_ff[i] || stage_load[i+1];
      end
   end

   assign req_ready  = stage_load[0];
   assign req_accept = req_valid && req_ready;

   always_comb begin
      pipe_valid_in[0] = stage_load[0] ? (req_accept && req_data.is_last) : pipe_valid_ff[0];
      for (int i = 1; i < 6; i++) begin
         pipe_valid_in[i] = stage_load[i] ? pipe_valid_ff[i-1] : pipe_valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= '0;
      end else begin
         pipe_valid_ff <= pipe_valid_in;
      end
   end

   // ---------------- byte parser ----------------
   always_comb begin
      logic        skip;
      logic        digit;
      logic [7:0]  c;
      logic [3:0]  dval;
      logic [34:0] grown;
      parse_next = parse_ff;
      skip       = 1'b0;
      c          = req_data.char_code;
      digit      = ttp_pkg::is_digit(c);
      dval       = c[3:0];
      grown      = '0;
      if (!parse_ff.failed) begin
         if (parse_next.phase == ttp_pkg::PH_SIGN) begin
            if (ttp_pkg::is_sign(c)) begin
               parse_next.negative = (c == ttp_pkg::CH_MINUS);
               parse_next.phase    = ttp_pkg::PH_SIGN2;
               skip                = 1'b1;
            end else begin
               parse_next.phase = ttp_pkg::PH_HOUR;
            end
         end else if (parse_next.phase == ttp_pkg::PH_SIGN2) begin
            if (ttp_pkg::is_sign(c)) begin
               parse_next.failed = 1'b1;
               skip              = 1'b1;
            end else begin
               parse_next.phase = ttp_pkg::PH_HOUR;
            end
         end
         if (!skip) begin
            case (parse_next.phase)
               ttp_pkg::PH_HOUR: begin
                  if (digit) begin
                     grown = ttp_pkg::times_ten_plus(parse_next.hour_field, dval);
                     if (grown > ttp_pkg::FIELD_MAX) parse_next.failed = 1'b1;
                     else parse_next.hour_field = grown[30:0];
                     parse_next.field_seen[0] = 1'b1;
                  end else if (c == ttp_pkg::CH_COLON) begin
                     if (parse_next.hour_field > {9'd0, hour_limit_ff}) parse_next.failed = 1'b1;
                     parse_next.phase = ttp_pkg::PH_MIN;
                  end else begin
                     parse_next.failed = 1'b1;
                  end
               end
               ttp_pkg::PH_MIN: begin
                  if (digit) begin
                     grown = ttp_pkg::times_ten_plus(parse_next.minute_field, dval);
                     if (grown > ttp_pkg::FIELD_MAX) parse_next.failed = 1'b1;
                     else parse_next.minute_field = grown[30:0];
                     parse_next.field_seen[1] = 1'b1;
                  end else if (!parse_next.field_seen[1]) begin
                     parse_next.failed = 1'b1;
                  end else if (c == ttp_pkg::CH_COLON) begin
                     parse_next.phase         = ttp_pkg::PH_SEC;
                     parse_next.field_seen[2] = 1'b1;
                  end else if (c == ttp_pkg::CH_DOT || c == ttp_pkg::CH_COMMA) begin
                     parse_next.phase = ttp_pkg::PH_FRAC;
                  end else begin
                     parse_next.phase = ttp_pkg::after_time(c);
                  end
               end
               ttp_pkg::PH_SEC: begin
                  if (digit) begin
                     grown = ttp_pkg::times_ten_plus(parse_next.second_field, dval);
                     if (grown > ttp_pkg::FIELD_MAX) parse_next.failed = 1'b1;
                     else parse_next.second_field = grown[30:0];
                     parse_next.field_seen[3] = 1'b1;
                  end else if (!parse_next.field_seen[3]) begin
                     parse_next.failed = 1'b1;
                  end else if (c == ttp_pkg::CH_DOT || c == ttp_pkg::CH_COMMA) begin
                     parse_next.phase = ttp_pkg::PH_FRAC;
                  end else begin
                     parse_next.phase = ttp_pkg::after_time(c);
                  end
               end
               ttp_pkg::PH_FRAC: begin
                  if (digit) begin
                     if (parse_next.fraction_digits < FRAC_KEEP) begin
                        grown = ttp_pkg::times_ten_plus({1'b0, parse_next.fraction_field}, dval);
                        parse_next.fraction_field  = grown[29:0];
                        parse_next.fraction_digits = parse_next.fraction_digits + 4'd1;
                     end else if (parse_next.fraction_digits == FRAC_KEEP) begin
                        // first digit past the kept ones rounds half up
                        if (c >= ttp_pkg::CH_FIVE) begin
                           parse_next.fraction_field = parse_next.fraction_field + 30'd1;
                        end
                        parse_next.fraction_digits = parse_next.fraction_digits + 4'd1;
                     end
                  end else begin
                     parse_next.phase = ttp_pkg::after_time(c);
                  end
               end
               ttp_pkg::PH_MER_A, ttp_pkg::PH_MER_P: begin
                  if (c == ttp_pkg::CH_UC_M || c == ttp_pkg::CH_LC_M) begin
                     parse_next.meridian = (parse_next.phase == ttp_pkg::PH_MER_A) ?
                                           ttp_pkg::MER_AM : ttp_pkg::MER_PM;
                     parse_next.phase    = ttp_pkg::PH_DONE;
                  end else begin
                     parse_next.phase = ttp_pkg::PH_TRAIL;
                  end
               end
               default: begin
                  parse_next.phase = ttp_pkg::PH_TRAIL;
               end
            endcase
         end
      end
   end

   always_comb begin
      parse_in = parse_ff;
      if (req_accept) begin
         parse_in = req_data.is_last ? ttp_pkg::PARSE_CLEAR : parse_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parse_ff <= ttp_pkg::PARSE_CLEAR;
      end else begin
         parse_ff <= parse_in;
      end
   end

   // stage 1: snapshot of the finished string
   always_ff @(posedge clock) begin
      if (stage_load[0]) begin
         s1_ff <= parse_next;
      end
   end

   // ---------------- stage 2: checks, meridian, hours to minutes ----------------
   always_comb begin
      logic [21:0] hr;
      logic [3:0]  kept;
      logic [59:0] frac_prod;
      s2_in.bad = s1_ff.failed ||
                  s1_ff.phase == ttp_pkg::PH_SIGN || s1_ff.phase == ttp_pkg::PH_SIGN2 ||
                  s1_ff.phase == ttp_pkg::PH_HOUR ||
                  (s1_ff.phase == ttp_pkg::PH_MIN && !s1_ff.field_seen[1]) ||
                  (s1_ff.phase == ttp_pkg::PH_SEC && !s1_ff.field_seen[3]);
      // no seconds and a nonzero fraction reads as M:SS.frac
      s2_in.hour_mode = s1_ff.field_seen[2] || (s1_ff.fraction_field == 30'd0);
      // the leading field passed the limit check, so it fits in 22 bits
      hr = s1_ff.hour_field[21:0];
      if (s1_ff.meridian != ttp_pkg::MER_NONE) begin
         if (s2_in.hour_mode) begin
            if (hr > ttp_pkg::MERIDIAN_HOURS) s2_in.bad = 1'b1;
            if (hr == ttp_pkg::MERIDIAN_HOURS) hr = 22'd0;
            if (s1_ff.meridian == ttp_pkg::MER_PM) hr = hr + ttp_pkg::MERIDIAN_HOURS;
         end else begin
            s2_in.bad = 1'b1;
         end
      end
      s2_in.minutes = 32'({hr, 6'b000000}) - 32'({hr, 2'b00}) + 32'(s1_ff.minute_field);
      kept = (s1_ff.fraction_digits > FRAC_KEEP) ? FRAC_KEEP : s1_ff.fraction_digits;
      frac_prod = 60'(s1_ff.fraction_field) *
                  60'(ttp_pkg::pow10(ttp_pkg::SCALE_DIGITS - kept));
      s2_in.fraction = frac_prod[29:0];
      s2_in.seconds  = s1_ff.second_field;
      s2_in.negative = s1_ff.negative;
      s2_in.trailing = s1_ff.phase == ttp_pkg::PH_TRAIL || s1_ff.phase == ttp_pkg::PH_MER_A ||
                       s1_ff.phase == ttp_pkg::PH_MER_P;
   end

   always_ff @(posedge clock) begin
      if (stage_load[1]) begin
         s2_ff <= s2_in;
      end
   end

   // ---------------- stage 3: whole units before the 1e9 scale ----------------
   always_comb begin
      s3_in.bad      = s2_ff.bad;
      s3_in.whole    = s2_ff.hour_mode ?
                       ({s2_ff.minutes, 6'b000000} - {4'd0, s2_ff.minutes, 2'b00} +
                        38'(s2_ff.seconds)) :
                       38'(s2_ff.minutes);
      s3_in.fraction = s2_ff.fraction;
      s3_in.negative = s2_ff.negative;
      s3_in.trailing = s2_ff.trailing;
   end

   always_ff @(posedge clock) begin
      if (stage_load[2]) begin
         s3_ff <= s3_in;
      end
   end

   // ---------------- stage 4: multiply by 1e9 in two parts ----------------
   always_comb begin
      s4_in.bad      = s3_ff.bad;
      s4_in.prod_lo  = 62'(s3_ff.whole[31:0]) * 62'(ttp_pkg::NS_PER_SEC);
      s4_in.prod_hi  = 36'(s3_ff.whole[37:32]) * 36'(ttp_pkg::NS_PER_SEC);
      s4_in.fraction = s3_ff.fraction;
      s4_in.negative = s3_ff.negative;
      s4_in.trailing = s3_ff.trailing;
   end

   always_ff @(posedge clock) begin
      if (stage_load[3]) begin
         s4_ff <= s4_in;
      end
   end

   // ---------------- stage 5: total and range check ----------------
   always_comb begin
      logic [68:0] total;
      total = {1'b0, s4_ff.prod_hi, 32'd0} + {7'd0, s4_ff.prod_lo} + {39'd0, s4_ff.fraction};
      s5_in.good      = !s4_ff.bad && (total <= {6'd0, ttp_pkg::TOTAL_MAX});
      s5_in.magnitude = total[62:0];
      s5_in.negative  = s4_ff.negative;
      s5_in.trailing  = s4_ff.trailing;
   end

   always_ff @(posedge clock) begin
      if (stage_load[4]) begin
         s5_ff <= s5_in;
      end
   end

   // ---------------- output register ----------------
   always_comb begin
      rsp_data_in.ok               = s5_ff.good;
      rsp_data_in.trailing_ignored = s5_ff.good && s5_ff.trailing;
      if (!s5_ff.good) begin
         rsp_data_in.nanoseconds = 64'sd0;
      end else if (s5_ff.negative) begin
         rsp_data_in.nanoseconds = 64'd0 - {1'b0, s5_ff.magnitude};
      end else begin
         rsp_data_in.nanoseconds = {1'b0, s5_ff.magnitude};
      end
   end

   always_ff @(posedge clock) begin
      if (stage_load[5]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = pipe_valid_ff[5];
   assign rsp_data  = rsp_data_ff;

   // ---------------- assertions ----------------
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.is_last) |=>
      (parse_ff.phase == ttp_pkg::PH_SIGN && !parse_ff.failed))
      else $error("parser state not cleared after last byte");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (&pipe_valid_ff))
      else $error("input stalled with a free pipeline stage");

   a_hour_limit_write: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && pready && paddr[2] == ttp_pkg::CSR_HOUR_LIMIT) |=>
      (hour_limit_ff == $past(pwdata[21:0])))
      else $error("hour_limit write lost");

endmodule

// File: tb/tb_time_text_parser.sv
// tb_time_text_parser: self-checking testbench for the time text parser
// feeds directed and random time strings byte by byte under several hour limits
// depends on ttp_pkg and time_text_parser
`timescale 1ns / 1ps

module tb_time_text_parser;

   localparam int          FRAC_KEEP    = 9;
   localparam int          QUIET_LIMIT  = 600;
   localparam int          DRAIN_CYCLES = 12;
   localparam int          PHASE_BYTES  = 66;
   localparam logic [63:0] DURATION_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] NS_HOUR      = 64'd3_600_000_000_000;
   localparam logic [63:0] NS_MINUTE    = 64'd60_000_000_000;
   localparam logic [63:0] NS_SECOND    = 64'd1_000_000_000;

   typedef logic [7:0] text_type[$];

   // predicts the duration for every string and checks the returned results
   class time_scoreboard;
      logic [21:0]           hour_limit;
      ttp_pkg::phase_type    phase;
      logic                  negative;
      logic [31:0]           hours;
      logic [31:0]           minutes;
      logic [31:0]           seconds;
      logic [29:0]           fraction;
      int unsigned           frac_count;
      logic [3:0]            seen;
      ttp_pkg::meridian_type mer;
      logic                  failed;
      logic                  overflowed;
      ttp_pkg::rsp_data_type expected_times[$];
      int                    failures;

      function new();
         hour_limit = 22'd2562047;
         failures = 0;
         clear_text();
      endfunction

      function void clear_text();
         phase = ttp_pkg::PH_SIGN;
         negative = 1'b0;
         hours = '0;
         minutes = '0;
         seconds = '0;
         fraction = '0;
         frac_count = 0;
         seen = '0;
         mer = ttp_pkg::MER_NONE;
         failed = 1'b0;
      endfunction

      function logic [31:0] grow(logic [31:0] f, logic [7:0] c);
         logic [63:0] v;
         v = 64'(f) * 64'd10 + 64'(c - ttp_pkg::CH_ZERO);
         if (v > 64'd2147483647) begin
            failed = 1'b1;
            return f;
         end
         return v[31:0];
      endfunction

      function ttp_pkg::phase_type closing_phase(logic [7:0] c);
         if (c == ttp_pkg::CH_UC_A || c == ttp_pkg::CH_LC_A) return ttp_pkg::PH_MER_A;
         if (c == ttp_pkg::CH_UC_P || c == ttp_pkg::CH_LC_P) return ttp_pkg::PH_MER_P;
         return ttp_pkg::PH_TRAIL;
      endfunction

      function void scan_char(logic [7:0] c);
         logic numeral;
         logic sign;
         numeral = (c >= ttp_pkg::CH_ZERO) && (c <= ttp_pkg::CH_NINE);
         sign = (c == ttp_pkg::CH_PLUS) || (c == ttp_pkg::CH_MINUS);
         if (phase == ttp_pkg::PH_SIGN) begin
            if (sign) begin
               negative = (c == ttp_pkg::CH_MINUS);
               phase = ttp_pkg::PH_SIGN2;
               return;
            end
            phase = ttp_pkg::PH_HOUR;
         end else if (phase == ttp_pkg::PH_SIGN2) begin
            if (sign) begin
               failed = 1'b1;
               return;
            end
            phase = ttp_pkg::PH_HOUR;
         end
         case (phase)
            ttp_pkg::PH_HOUR: begin
               if (numeral) begin
                  hours = grow(hours, c);
                  seen[0] = 1'b1;
               end else if (c == ttp_pkg::CH_COLON) begin
                  if (hours > 32'(hour_limit)) failed = 1'b1;
                  phase = ttp_pkg::PH_MIN;
               end else failed = 1'b1;
            end
            ttp_pkg::PH_MIN: begin
               if (numeral) begin
                  minutes = grow(minutes, c);
                  seen[1] = 1'b1;
               end else if (!seen[1]) failed = 1'b1;
               else if (c == ttp_pkg::CH_COLON) begin
                  phase = ttp_pkg::PH_SEC;
                  seen[2] = 1'b1;
               end else if (c == ttp_pkg::CH_DOT || c == ttp_pkg::CH_COMMA) begin
                  phase = ttp_pkg::PH_FRAC;
               end else phase = closing_phase(c);
            end
            ttp_pkg::PH_SEC: begin
               if (numeral) begin
                  seconds = grow(seconds, c);
                  seen[3] = 1'b1;
               end else if (!seen[3]) failed = 1'b1;
               else if (c == ttp_pkg::CH_DOT || c == ttp_pkg::CH_COMMA) begin
                  phase = ttp_pkg::PH_FRAC;
               end else phase = closing_phase(c);
            end
            ttp_pkg::PH_FRAC: begin
               if (numeral) begin
                  // digits past the kept ones only round, once
                  if (frac_count < FRAC_KEEP) begin
                     fraction = fraction * 30'd10 + 30'(c - ttp_pkg::CH_ZERO);
                     frac_count++;
                  end else if (frac_count == FRAC_KEEP) begin
                     if (c >= ttp_pkg::CH_FIVE) fraction = fraction + 30'd1;
                     frac_count++;
                  end
               end else phase = closing_phase(c);
            end
            ttp_pkg::PH_MER_A, ttp_pkg::PH_MER_P: begin
               if (c == ttp_pkg::CH_UC_M || c == ttp_pkg::CH_LC_M) begin
                  mer = (phase == ttp_pkg::PH_MER_A) ? ttp_pkg::MER_AM : ttp_pkg::MER_PM;
                  phase = ttp_pkg::PH_DONE;
               end else phase = ttp_pkg::PH_TRAIL;
            end
            default: phase = ttp_pkg::PH_TRAIL;
         endcase
      endfunction

      function logic [63:0] add_scaled(logic [63:0] acc, logic [63:0] v, logic [63:0] k);
         if (v != 0 && v > (DURATION_MAX - acc) / k) begin
            overflowed = 1'b1;
            return acc;
         end
         return acc + v * k;
      endfunction

      function ttp_pkg::rsp_data_type resolve_time();
         ttp_pkg::rsp_data_type r;
         logic                  bad;
         logic [63:0]           total;
         logic [63:0]           frac;
         logic [63:0]           h;
         int unsigned           n;
         r = '0;
         overflowed = 1'b0;
         total = '0;
         h = 64'(hours);
         bad = failed || phase == ttp_pkg::PH_SIGN || phase == ttp_pkg::PH_SIGN2 ||
               phase == ttp_pkg::PH_HOUR ||
               (phase == ttp_pkg::PH_MIN && !seen[1]) ||
               (phase == ttp_pkg::PH_SEC && !seen[3]);
         n = (frac_count > FRAC_KEEP) ? FRAC_KEEP : frac_count;
         frac = 64'(fraction);
         for (int i = n; i < 9; i++) frac = frac * 64'd10;
         if (!bad) begin
            if (seen[2] || frac == 0) begin
               if (mer != ttp_pkg::MER_NONE) begin
                  if (h > 64'd12) bad = 1'b1;
                  if (h == 64'd12) h = '0;
                  if (mer == ttp_pkg::MER_PM) h = h + 64'd12;
               end
               total = add_scaled(total, h, NS_HOUR);
               total = add_scaled(total, 64'(minutes), NS_MINUTE);
               total = add_scaled(total, 64'(seconds), NS_SECOND);
            end else begin
               // minutes and seconds with a fraction
               if (mer != ttp_pkg::MER_NONE) bad = 1'b1;
               total = add_scaled(total, h, NS_MINUTE);
               total = add_scaled(total, 64'(minutes), NS_SECOND);
            end
            total = add_scaled(total, frac, 64'd1);
         end
         if (bad || overflowed) return r;
         r.ok = 1'b1;
         r.nanoseconds = negative ? 64'd0 - total : total;
         r.trailing_ignored = (phase == ttp_pkg::PH_TRAIL || phase == ttp_pkg::PH_MER_A ||
                               phase == ttp_pkg::PH_MER_P);
         return r;
      endfunction

      function void note_char(ttp_pkg::req_data_type t);
         if (!failed) scan_char(t.char_code);
         if (t.is_last) begin
            expected_times.push_back(resolve_time());
            clear_text();
         end
      endfunction

      function void check_time(ttp_pkg::rsp_data_type got);
         ttp_pkg::rsp_data_type want;
         if (expected_times.size() == 0) begin
            $error("result with no string pending: ok %0d ns %0d", got.ok, got.nanoseconds);
            failures++;
            return;
         end
         want = expected_times.pop_front();
         if (got.ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, got.ok);
            failures++;
         end
         if (got.nanoseconds !== want.nanoseconds) begin
            $error("nanoseconds: expected %0d, got %0d", want.nanoseconds, got.nanoseconds);
            failures++;
         end
         if (got.trailing_ignored !== want.trailing_ignored) begin
            $error("trailing_ignored: expected %0d, got %0d",
                   want.trailing_ignored, got.trailing_ignored);
            failures++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   ttp_pkg::req_data_type req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   ttp_pkg::rsp_data_type rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [2:0]            paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   time_scoreboard sb;
   logic           req_calm;
   int             rsp_calm_left;
   int             quiet_cycles;
   int             bytes_sent;

   time_text_parser #(.FRACTION_DIGITS(FRAC_KEEP)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // both monitors in one block so a transaction is seen once per edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_char(req_data);
         if (rsp_valid && rsp_ready) sb.check_time(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL time_text_parser");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: a random stall before each result, with calm stretches
   initial begin
      int stall;
      rsp_ready <= 1'b0;
      rsp_calm_left = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_calm_left > 0) begin
            stall = 0;
            rsp_calm_left--;
         end else begin
            stall = $urandom_range(0, 8);
            if ($urandom_range(0, 9) == 0) rsp_calm_left = $urandom_range(4, 12);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic push_byte(input logic [7:0] c, input logic last);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{char_code: c, is_last: last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_text(input text_type text);
      req_calm = ($urandom_range(0, 3) == 0);
      foreach (text[i]) push_byte(text[i], i == text.size() - 1);
      bytes_sent += text.size();
   endtask

   // lets the parser fall idle, then moves the hour limit
   task automatic write_hour_limit(input logic [21:0] value);
      req_valid <= 1'b0;
      while (sb.expected_times.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {ttp_pkg::CSR_HOUR_LIMIT, 2'b00};
      pwdata <= {10'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      sb.hour_limit = value;
   endtask

   function automatic text_type digits(input int count);
      text_type t;
      int style;
      style = $urandom_range(0, 5);
      repeat (count) begin
         case (style)
            0: t.push_back(ttp_pkg::CH_ZERO);
            1: t.push_back(ttp_pkg::CH_NINE);
            default: t.push_back(ttp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
         endcase
      end
      return t;
   endfunction

   function automatic int field_width();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 80) return 0;
      if (r < 93) return $urandom_range(3, 7);
      return $urandom_range(8, 11);
   endfunction

   // mostly well-formed times with random content, some broken or pure noise
   function automatic text_type random_text();
      text_type t;
      int shape;
      int cut;
      shape = $urandom_range(0, 99);
      if (shape < 10) begin
         repeat ($urandom_range(1, 8)) t.push_back(8'($urandom_range(0, 255)));
         return t;
      end
      case ($urandom_range(0, 3))
         0: t.push_back(ttp_pkg::CH_PLUS);
         1: t.push_back(ttp_pkg::CH_MINUS);
         default: ;
      endcase
      if (shape < 14) t.push_back($urandom_range(0, 1) ? ttp_pkg::CH_PLUS : ttp_pkg::CH_MINUS);
      t = {t, digits(field_width())};
      if (shape < 18) t.push_back(8'($urandom_range(0, 255)));
      else t.push_back(ttp_pkg::CH_COLON);
      t = {t, digits(field_width())};
      if ($urandom_range(0, 1)) begin
         t.push_back(ttp_pkg::CH_COLON);
         t = {t, digits(field_width())};
      end
      if ($urandom_range(0, 99) < 45) begin
         t.push_back($urandom_range(0, 1) ? ttp_pkg::CH_DOT : ttp_pkg::CH_COMMA);
         t = {t, digits($urandom_range(0, 12))};
      end
      if ($urandom_range(0, 99) < 30) begin
         case ($urandom_range(0, 3))
            0: t.push_back(ttp_pkg::CH_UC_A);
            1: t.push_back(ttp_pkg::CH_LC_A);
            2: t.push_back(ttp_pkg::CH_UC_P);
            default: t.push_back(ttp_pkg::CH_LC_P);
         endcase
         if ($urandom_range(0, 99) < 85) begin
            t.push_back($urandom_range(0, 1) ? ttp_pkg::CH_UC_M : ttp_pkg::CH_LC_M);
         end
      end
      if ($urandom_range(0, 99) < 20)
         repeat ($urandom_range(1, 4)) t.push_back(8'($urandom_range(0, 255)));
      if (shape >= 92)
         t.insert($urandom_range(0, t.size() - 1),
                  $urandom_range(0, 1) ? ttp_pkg::CH_PLUS : ttp_pkg::CH_MINUS);
      if (shape >= 18 && shape < 26 && t.size() > 1) begin
         cut = $urandom_range(1, t.size() - 1);
         t = t[0:cut-1];
      end
      if (t.size() == 0) t.push_back(ttp_pkg::CH_COLON);
      return t;
   endfunction

   task automatic random_phase();
      int target;
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) send_text(random_text());
   endtask

   initial begin
      string    probes[] = '{
         "+-1:00", "1:-5", "-1:30-x", "12", "5x:00", "1:", "1:02:",
         "2147483648:00", "2562048:00", "2562047:47:16.854775807",
         "-2562047:47:16.854775808", "0:01.1234567895", "1:02,000",
         "12:30am", "12:05PM", "13:00pm", "1:02.5pm", "3:04:05.6789Ax",
         ":59", "0:00.9999999999"};
      text_type text;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      req_calm = 1'b0;
      bytes_sent = 0;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (probes[i]) begin
         text = {};
         for (int j = 0; j < probes[i].len(); j++) text.push_back(probes[i][j]);
         send_text(text);
      end
      // zero byte and top byte as trailing text
      send_text('{ttp_pkg::CH_NINE, ttp_pkg::CH_COLON, ttp_pkg::CH_FIVE, ttp_pkg::CH_NINE,
                  8'h00, 8'hFF});
      random_phase();

      write_hour_limit(22'd0);
      random_phase();
      write_hour_limit(22'd12);
      random_phase();
      write_hour_limit(22'd2562047);
      random_phase();
      write_hour_limit(22'($urandom_range(0, 2562047)));
      random_phase();

      req_valid <= 1'b0;
      while (sb.expected_times.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.expected_times.size() == 0) begin
         $display("PASS time_text_parser");
      end else begin
         $display("FAIL time_text_parser");
      end
      $finish;
   end

endmodule

// File: files.f
sv/ttp_pkg.sv
sv/time_text_parser.sv
tb/tb_time_text_parser.sv
